### sv/thc_pkg.sv
`default_nettype none

package thc_pkg;

    localparam int unsigned SecPeriodW = 16;
    localparam int unsigned HoldDelayW = 16;
    localparam int unsigned RepPeriodW = 8;
    localparam int unsigned DwellW     = 8;
    localparam int unsigned CfgDataW   = 16;
    localparam int unsigned CfgIndexW  = 2;

    localparam logic [SecPeriodW-1:0] SEC_PERIOD_RST = 16'd998;
    localparam logic [HoldDelayW-1:0] HOLD_DELAY_RST = 16'd1000;
    localparam logic [RepPeriodW-1:0] REP_PERIOD_RST = 8'd4;
    localparam logic [DwellW-1:0]     DWELL_RST      = 8'd1;

    localparam logic [5:0] MINUTE_RST = 6'd59;
    localparam logic [3:0] HOUR_RST   = 4'd1;
    localparam logic [6:0] SIXTY      = 7'd60;
    localparam logic [4:0] THIRTEEN   = 5'd13;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_SEC_PERIOD = 2'd0,
        CFG_HOLD_DELAY = 2'd1,
        CFG_REP_PERIOD = 2'd2,
        CFG_DWELL      = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SCAN_HOUR_TENS  = 2'd0,
        SCAN_HOUR_UNITS = 2'd1,
        SCAN_MIN_TENS   = 2'd2,
        SCAN_MIN_UNITS  = 2'd3
    } scan_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } bcd_t;

    function automatic bcd_t to_bcd(input logic [5:0] value);
        bcd_t r;
        if (value >= 6'd50)
        begin
            r.tens  = 4'd5;
            r.units = 4'(value - 6'd50);
        end
        else if (value >= 6'd40)
        begin
            r.tens  = 4'd4;
            r.units = 4'(value - 6'd40);
        end
        else if (value >= 6'd30)
        begin
            r.tens  = 4'd3;
            r.units = 4'(value - 6'd30);
        end
        else if (value >= 6'd20)
        begin
            r.tens  = 4'd2;
            r.units = 4'(value - 6'd20);
        end
        else if (value >= 6'd10)
        begin
            r.tens  = 4'd1;
            r.units = 4'(value - 6'd10);
        end
        else
        begin
            r.tens  = 4'd0;
            r.units = value[3:0];
        end
        return r;
    endfunction

    // digits above nine show as nine
    function automatic logic [6:0] seg_font(input logic [3:0] digit);
        logic [6:0] s;
        case (digit)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            default: s = 7'h6F;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### sv/thc_if.sv
`default_nettype none

interface thc_tick_if;
    logic valid;
    logic ready;
    logic button;

    modport source (output valid, output button, input ready);
    modport sink (input valid, input button, output ready);
endinterface

interface thc_disp_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_select_n;
    logic [6:0] segments;
    logic       dot;

    modport source (output valid, output digit_select_n, output segments, output dot,
                    input ready);
    modport sink (input valid, input digit_select_n, input segments, input dot,
                  output ready);
endinterface

`default_nettype wire

### sv/twelve_hour_clock_seven_segment_mux.sv
// the display item for a tick is presented in the cycle after the tick is taken
// throughput: one tick item per cycle while the display side is ready; the output
// register is the only stage and is refilled in the same cycle it is emptied
// reset: asynchronous active low; time goes to 1:59:00, counters clear, registers
// return to their default periods
`default_nettype none

module twelve_hour_clock_seven_segment_mux
    import thc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    thc_tick_if.sink                  tick,
    thc_disp_if.source                disp,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data
);

    logic [SecPeriodW-1:0] sec_period_reg;
    logic [HoldDelayW-1:0] hold_delay_reg;
    logic [RepPeriodW-1:0] rep_period_reg;
    logic [DwellW-1:0]     dwell_period_reg;

    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [7:0]  repeat_count_reg, repeat_count_next;
    logic        edge_armed_reg, edge_armed_next;
    logic [5:0]  second_reg, second_next;
    logic [5:0]  minute_reg, minute_next;
    logic [3:0]  hour_reg, hour_next;
    logic [7:0]  dwell_count_reg, dwell_count_next;
    logic [1:0]  scan_reg, scan_next;

    logic        out_valid_reg;
    logic [3:0]  digit_sel_reg, digit_sel_next;
    logic [6:0]  segments_reg, segments_next;
    logic        dot_reg, dot_next;

    logic        accept;
    logic [16:0] tick_sum;
    logic        sec_step;
    logic [6:0]  sec_sum;
    logic        sec_carry;
    logic [15:0] hold_inc;
    logic [7:0]  rep_inc;
    logic        rep_fire;
    logic        edge_fire;
    logic [6:0]  min_sum;
    logic [4:0]  hour_sum;
    logic [7:0]  dwell_inc;
    bcd_t        hour_bcd;
    bcd_t        min_bcd;
    logic [3:0]  digit;

    assign tick.ready = !out_valid_reg || disp.ready;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_period_reg   <= SEC_PERIOD_RST;
            hold_delay_reg   <= HOLD_DELAY_RST;
            rep_period_reg   <= REP_PERIOD_RST;
            dwell_period_reg <= DWELL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SEC_PERIOD: sec_period_reg   <= cfg_data[SecPeriodW-1:0];
                CFG_HOLD_DELAY: hold_delay_reg   <= cfg_data[HoldDelayW-1:0];
                CFG_REP_PERIOD: rep_period_reg   <= cfg_data[RepPeriodW-1:0];
                CFG_DWELL:      dwell_period_reg <= cfg_data[DwellW-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        tick_sum        = {1'b0, tick_count_reg} + 17'd1;
        sec_step        = tick_sum >= {1'b0, sec_period_reg};
        tick_count_next = sec_step ? 16'd0 : tick_sum[15:0];

        sec_sum   = {1'b0, second_reg} + {6'd0, sec_step};
        sec_carry = sec_sum >= SIXTY;
        second_next = sec_carry ? 6'd0 : sec_sum[5:0];

        hold_inc = (hold_count_reg != 16'hFFFF) ? hold_count_reg + 16'd1 : hold_count_reg;
        rep_inc  = repeat_count_reg + 8'd1;
        rep_fire = 1'b0;
        edge_fire = 1'b0;
        if (tick.button)
        begin
            hold_count_next   = hold_inc;
            repeat_count_next = repeat_count_reg;
            if (hold_inc >= hold_delay_reg)
            begin
                rep_fire          = rep_inc >= rep_period_reg;
                repeat_count_next = rep_fire ? 8'd0 : rep_inc;
            end
            edge_fire       = edge_armed_reg;
            edge_armed_next = 1'b0;
        end
        else
        begin
            hold_count_next   = 16'd0;
            repeat_count_next = 8'd0;
            edge_armed_next   = 1'b1;
        end

        min_sum = {1'b0, minute_reg} + {6'd0, rep_fire} + {6'd0, edge_fire}
                  + {6'd0, sec_carry};
        if (min_sum >= SIXTY)
        begin
            minute_next = 6'd0;
            hour_sum    = {1'b0, hour_reg} + 5'd1;
        end
        else
        begin
            minute_next = min_sum[5:0];
            hour_sum    = {1'b0, hour_reg};
        end
        if (hour_sum >= THIRTEEN || hour_sum == 5'd0)
            hour_next = 4'd1;
        else
            hour_next = hour_sum[3:0];

        hour_bcd = to_bcd({2'b00, hour_next});
        min_bcd  = to_bcd(minute_next);
        case (scan_t'(scan_reg))
            SCAN_HOUR_TENS:  digit = hour_bcd.tens;
            SCAN_HOUR_UNITS: digit = hour_bcd.units;
            SCAN_MIN_TENS:   digit = min_bcd.tens;
            SCAN_MIN_UNITS:  digit = min_bcd.units;
            default:         digit = min_bcd.units;
        endcase
        digit_sel_next = ~(4'b0001 << scan_reg);
        segments_next  = seg_font(digit);
        dot_next       = (scan_t'(scan_reg) == SCAN_HOUR_UNITS) && second_next[0];

        dwell_inc = dwell_count_reg + 8'd1;
        if (dwell_inc >= dwell_period_reg)
        begin
            dwell_count_next = 8'd0;
            scan_next        = scan_reg + 2'd1;
        end
        else
        begin
            dwell_count_next = dwell_inc;
            scan_next        = scan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= 16'd0;
            hold_count_reg   <= 16'd0;
            repeat_count_reg <= 8'd0;
            edge_armed_reg   <= 1'b1;
            second_reg       <= 6'd0;
            minute_reg       <= MINUTE_RST;
            hour_reg         <= HOUR_RST;
            dwell_count_reg  <= 8'd0;
            scan_reg         <= 2'd0;
        end
        else if (accept)
        begin
            tick_count_reg   <= tick_count_next;
            hold_count_reg   <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
            edge_armed_reg   <= edge_armed_next;
            second_reg       <= second_next;
            minute_reg       <= minute_next;
            hour_reg         <= hour_next;
            dwell_count_reg  <= dwell_count_next;
            scan_reg         <= scan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (tick.ready)
            out_valid_reg <= tick.valid;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            digit_sel_reg <= digit_sel_next;
            segments_reg  <= segments_next;
            dot_reg       <= dot_next;
        end
    end

    assign disp.valid          = out_valid_reg;
    assign disp.digit_select_n = digit_sel_reg;
    assign disp.segments       = segments_reg;
    assign disp.dot            = dot_reg;

endmodule

`default_nettype wire

### test/thc_checker.sv
`timescale 1ns / 1ps

module thc_checker
    import thc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    thc_tick_if                       tick,
    thc_disp_if                       disp,
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [3:0] digit_select_n;
        logic [6:0] segments;
        logic       dot;
    } disp_item_t;

    logic [SecPeriodW-1:0] sec_period;
    logic [HoldDelayW-1:0] hold_delay;
    logic [RepPeriodW-1:0] rep_period;
    logic [DwellW-1:0]     dwell_period;

    logic [15:0] tick_count;
    logic [15:0] hold_count;
    logic [7:0]  repeat_count;
    logic        edge_armed;
    logic [5:0]  second_value;
    logic [5:0]  minute_value;
    logic [3:0]  hour_value;
    logic [7:0]  dwell_count;
    logic [1:0]  scan_index;

    disp_item_t display_due_q [$];

    task automatic report_mismatch(input string msg);
        $display("thc_checker: %0t %s", $realtime, msg);
        fail_count = fail_count + 1;
    endtask

    task automatic step_clock_display(input logic pressed, output disp_item_t item);
        logic [3:0] digit;
        scan_t      pos;
        tick_count = tick_count + 16'd1;
        if (tick_count >= sec_period)
        begin
            tick_count   = '0;
            second_value = second_value + 6'd1;
        end
        if (pressed)
        begin
            if (hold_count != 16'hFFFF)
                hold_count = hold_count + 16'd1;
            if (hold_count >= hold_delay)
            begin
                repeat_count = repeat_count + 8'd1;
                if (repeat_count >= rep_period)
                begin
                    repeat_count = '0;
                    minute_value = minute_value + 6'd1;
                end
            end
            if (edge_armed)
            begin
                minute_value = minute_value + 6'd1;
                edge_armed   = 1'b0;
            end
        end
        else
        begin
            edge_armed   = 1'b1;
            hold_count   = '0;
            repeat_count = '0;
        end
        // carries, several minute steps may land in one tick
        if (second_value >= SIXTY)
        begin
            second_value = '0;
            minute_value = minute_value + 6'd1;
        end
        if (minute_value >= SIXTY)
        begin
            minute_value = '0;
            hour_value   = hour_value + 4'd1;
        end
        if (hour_value >= THIRTEEN || hour_value == 4'd0)
            hour_value = 4'd1;
        pos = scan_t'(scan_index);
        case (pos)
            SCAN_HOUR_TENS:  digit = 4'(hour_value / 4'd10);
            SCAN_HOUR_UNITS: digit = 4'(hour_value % 4'd10);
            SCAN_MIN_TENS:   digit = 4'(minute_value / 6'd10);
            default:         digit = 4'(minute_value % 6'd10);
        endcase
        case (digit)
            4'd0:    item.segments = 7'h3F;
            4'd1:    item.segments = 7'h06;
            4'd2:    item.segments = 7'h5B;
            4'd3:    item.segments = 7'h4F;
            4'd4:    item.segments = 7'h66;
            4'd5:    item.segments = 7'h6D;
            4'd6:    item.segments = 7'h7D;
            4'd7:    item.segments = 7'h07;
            4'd8:    item.segments = 7'h7F;
            default: item.segments = 7'h6F;
        endcase
        item.digit_select_n = ~(4'b0001 << scan_index);
        item.dot            = (pos == SCAN_HOUR_UNITS) && second_value[0];
        dwell_count = dwell_count + 8'd1;
        if (dwell_count >= dwell_period)
        begin
            dwell_count = '0;
            scan_index  = scan_index + 2'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        disp_item_t got;
        disp_item_t want;
        if (!rst_n)
        begin
            sec_period   = SEC_PERIOD_RST;
            hold_delay   = HOLD_DELAY_RST;
            rep_period   = REP_PERIOD_RST;
            dwell_period = DWELL_RST;
            tick_count   = '0;
            hold_count   = '0;
            repeat_count = '0;
            edge_armed   = 1'b1;
            second_value = '0;
            minute_value = MINUTE_RST;
            hour_value   = HOUR_RST;
            dwell_count  = '0;
            scan_index   = '0;
            display_due_q.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (disp.valid && disp.ready)
            begin
                got = {disp.digit_select_n, disp.segments, disp.dot};
                if (display_due_q.size() == 0)
                    report_mismatch($sformatf("display item %h with none expected", got));
                else
                begin
                    want = display_due_q.pop_front();
                    if (got.digit_select_n !== want.digit_select_n)
                        report_mismatch($sformatf("digit_select_n expected %h got %h",
                                                  want.digit_select_n, got.digit_select_n));
                    if (got.segments !== want.segments)
                        report_mismatch($sformatf("segments expected %h got %h",
                                                  want.segments, got.segments));
                    if (got.dot !== want.dot)
                        report_mismatch($sformatf("dot expected %b got %b",
                                                  want.dot, got.dot));
                end
            end
            if (tick.valid && tick.ready)
            begin
                step_clock_display(tick.button, want);
                display_due_q.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SEC_PERIOD: sec_period   = cfg_data;
                    CFG_HOLD_DELAY: hold_delay   = cfg_data;
                    CFG_REP_PERIOD: rep_period   = cfg_data[RepPeriodW-1:0];
                    default:        dwell_period = cfg_data[DwellW-1:0];
                endcase
            end
            pending = display_due_q.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import thc_pkg::*;

    localparam int CycleLimit = 5_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left  = 0;
    int gap_max     = 3;
    int burst_max   = 8;

    thc_tick_if tick_ch ();
    thc_disp_if disp_ch ();

    twelve_hour_clock_seven_segment_mux u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .disp      (disp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    thc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_ch),
        .disp       (disp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : receiver
        logic [15:0] pattern;
        pattern = 16'hFFFF;
        disp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       pattern = 16'hFFFF;
                    1:       pattern = 16'($urandom);
                    2:       pattern = 16'($urandom | $urandom);
                    default: pattern = 16'($urandom & $urandom);
                endcase
                if (pattern == '0)
                    pattern = 16'h0001;
            end
            disp_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
        end
    end

    task automatic send_tick(input logic level);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap > 0)
            begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        tick_ch.valid  <= 1'b1;
        tick_ch.button <= level;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_display();
        tick_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic program_clock(input logic [15:0] sec, input logic [15:0] hold,
                                 input logic [7:0] rep, input logic [7:0] dwell);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEC_PERIOD;
        cfg_data  <= sec;
        @(posedge clk);
        cfg_index <= CFG_HOLD_DELAY;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_index <= CFG_REP_PERIOD;
        cfg_data  <= {8'h00, rep};
        @(posedge clk);
        cfg_index <= CFG_DWELL;
        cfg_data  <= {8'h00, dwell};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] opening;
        logic [7:0]  zero_run;
        logic [15:0] sec;
        logic [15:0] hold;
        logic [7:0]  rep;
        logic [7:0]  dwell;
        int          n;
        int          k;
        int          run;
        bit          shaped;
        tick_ch.valid  <= 1'b0;
        tick_ch.button <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_SEC_PERIOD;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, first press rolls 1:59 into 2:00
        opening = 16'b0011_1100_1011_0000;
        for (k = 0; k < 16; k++)
            send_tick(opening[k]);
        drain_display();

        // zero periods, zero hold delay, coinciding minute steps
        program_clock(16'd0, 16'd0, 8'd0, 8'd0);
        zero_run = 8'b0010_1111;
        for (k = 0; k < 8; k++)
            send_tick(zero_run[k]);
        drain_display();

        for (int phase = 0; phase < 9; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       sec = 16'd0;
                1:       sec = 16'd1;
                2, 3:    sec = 16'($urandom_range(2, 6));
                4:       sec = 16'hFFFF;
                default: sec = 16'($urandom_range(7, 40));
            endcase
            case ($urandom_range(0, 4))
                0:       hold = 16'd0;
                1:       hold = 16'hFFFF;
                default: hold = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 4))
                0:       rep = 8'd0;
                1:       rep = 8'hFF;
                default: rep = 8'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 4))
                0:       dwell = 8'd0;
                1:       dwell = 8'hFF;
                default: dwell = 8'($urandom_range(1, 3));
            endcase
            program_clock(sec, hold, rep, dwell);
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_max = $urandom_range(1, 16);
            n = 0;
            while (n < 62)
            begin
                // mostly press and hold runs, sometimes random chatter
                shaped = ($urandom_range(0, 3) != 0);
                run = shaped ? $urandom_range(1, 48) : $urandom_range(1, 8);
                for (k = 0; k < run; k++)
                    send_tick(shaped ? 1'b1 : ($urandom_range(0, 1) == 1));
                n = n + run;
                if (shaped)
                begin
                    run = $urandom_range(1, 6);
                    for (k = 0; k < run; k++)
                        send_tick(1'b0);
                    n = n + run;
                end
            end
            drain_display();
        end

        // longest periods, a hold that stays short of the repeat delay
        program_clock(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        gap_max = 0;
        send_tick(1'b0);
        for (k = 0; k < 40; k++)
            send_tick(1'b1);
        for (k = 0; k < 4; k++)
            send_tick(1'b0);
        drain_display();

        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
